>>> src/b40wu_pkg.sv
// Shared types, constants and the digit-to-character map for the base-40 word unpacker.
package b40wu_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned LENGTH_W = 5;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned COUNT_W = 4;

   // 40^11 = 5^11 * 2^33: the weight of the top digit has 33 low zero bits
   localparam int unsigned WEIGHT_SHIFT = 33;
   localparam int unsigned HI_W = VALUE_W - WEIGHT_SHIFT;
   localparam logic [HI_W-1:0] TOP_WEIGHT_HI = 31'd48828125;
   localparam int unsigned REM_HI_W = 26;
   localparam int unsigned REM_W = REM_HI_W + WEIGHT_SHIFT;

   localparam int unsigned QUOT_W = 6;
   localparam int unsigned QUOT_MAX = 43;
   localparam logic [QUOT_W-1:0] RADIX = 6'd40;

   localparam logic [QUOT_W-1:0] DIGIT_SPACE = 6'd0;
   localparam logic [QUOT_W-1:0] DIGIT_LETTER_LO = 6'd1;
   localparam logic [QUOT_W-1:0] DIGIT_LETTER_HI = 6'd26;
   localparam logic [QUOT_W-1:0] DIGIT_DOLLAR = 6'd27;
   localparam logic [QUOT_W-1:0] DIGIT_DOT = 6'd28;
   localparam logic [QUOT_W-1:0] DIGIT_UNDERSCORE = 6'd29;
   localparam logic [QUOT_W-1:0] DIGIT_NUM_LO = 6'd30;
   localparam logic [QUOT_W-1:0] DIGIT_NUM_HI = 6'd39;

   localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_LETTER_BASE = 8'h40;
   localparam logic [CHAR_W-1:0] ASCII_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] ASCII_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] ASCII_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_PAD = 8'h00;

   typedef struct packed {
      logic load;
      logic divide;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic last;
      logic out_free;
   } sts_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [QUOT_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      case (d) inside
         DIGIT_SPACE:                       ch = ASCII_SPACE;
         [DIGIT_LETTER_LO:DIGIT_LETTER_HI]: ch = ASCII_LETTER_BASE + CHAR_W'(d);
         DIGIT_DOLLAR:                      ch = ASCII_DOLLAR;
         DIGIT_DOT:                         ch = ASCII_DOT;
         DIGIT_UNDERSCORE:                  ch = ASCII_UNDERSCORE;
         [DIGIT_NUM_LO:DIGIT_NUM_HI]:       ch = ASCII_ZERO + CHAR_W'(d - DIGIT_NUM_LO);
         default:                           ch = ASCII_PAD;
      endcase
      return ch;
   endfunction

endpackage

>>> src/b40wu_dp.sv
// Datapath: word register, top-digit compare bank, remainder, counters and output register.
module b40wu_dp #(
   parameter int MAX_OUT_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  b40wu_pkg::cmd_type                  cmd,
   output b40wu_pkg::sts_type                  sts,
   input  logic [b40wu_pkg::VALUE_W-1:0]       req_encoded_value,
   input  logic [b40wu_pkg::LENGTH_W-1:0]      req_out_length,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [b40wu_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                                rsp_is_last,
   output logic [b40wu_pkg::COUNT_W-1:0]       rsp_decoded_count
);

   localparam int unsigned LEN_W = $clog2(MAX_OUT_BYTES + 1);

   logic [b40wu_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [b40wu_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [b40wu_pkg::QUOT_W-1:0]   digit_ff, digit_in;
   logic                           nz_ff, nz_in;
   logic [LEN_W-1:0]               left_ff, left_in;
   logic [b40wu_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [b40wu_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                           last_ff, last_in;
   logic [b40wu_pkg::COUNT_W-1:0]  dcount_ff, dcount_in;
   logic                           valid_ff, valid_in;

   logic [LEN_W-1:0]               len_clamp;
   logic [b40wu_pkg::HI_W-1:0]     value_hi;
   logic [b40wu_pkg::QUOT_MAX+1:1] hit;
   logic [b40wu_pkg::QUOT_W-1:0]   quot;
   logic [b40wu_pkg::HI_W-1:0]     sub_hi;
   logic [b40wu_pkg::HI_W-1:0]     rem_hi;
   logic [b40wu_pkg::COUNT_W-1:0]  count_next;

   always_comb begin
      if (int'(req_out_length) > MAX_OUT_BYTES) begin
         len_clamp = LEN_W'(MAX_OUT_BYTES);
      end else begin
         len_clamp = LEN_W'(req_out_length);
      end
   end

   assign value_hi = value_ff[b40wu_pkg::VALUE_W-1:b40wu_pkg::WEIGHT_SHIFT];

   // Compare the upper part against every multiple of the top weight at once;
   // the highest multiple that fits gives the quotient and what to subtract.
   always_comb begin
      hit = '0;
      quot = '0;
      sub_hi = '0;
      for (int k = 1; k <= b40wu_pkg::QUOT_MAX; k++) begin
         hit[k] = (value_hi >= b40wu_pkg::HI_W'(k) * b40wu_pkg::TOP_WEIGHT_HI);
      end
      for (int k = 1; k <= b40wu_pkg::QUOT_MAX; k++) begin
         if (hit[k] && !hit[k+1]) begin
            quot = quot | b40wu_pkg::QUOT_W'(k);
            sub_hi = sub_hi | (b40wu_pkg::HI_W'(k) * b40wu_pkg::TOP_WEIGHT_HI);
         end
      end
   end

   assign rem_hi = value_hi - sub_hi;
   assign count_next = count_ff + b40wu_pkg::COUNT_W'(nz_ff);

   always_comb begin
      value_in = value_ff;
      rem_in = rem_ff;
      digit_in = digit_ff;
      nz_in = nz_ff;
      left_in = left_ff;
      count_in = count_ff;
      char_in = char_ff;
      last_in = last_ff;
      dcount_in = dcount_ff;
      valid_in = valid_ff & ~rsp_tready;
      if (cmd.load) begin
         value_in = req_encoded_value;
         left_in = len_clamp;
         count_in = '0;
      end
      if (cmd.divide) begin
         // a top quotient of 40 or more only arises for the first digit; drop the excess
         digit_in = (quot >= b40wu_pkg::RADIX) ? quot - b40wu_pkg::RADIX : quot;
         nz_in = (value_ff != '0);
         rem_in = {rem_hi[b40wu_pkg::REM_HI_W-1:0], value_ff[b40wu_pkg::WEIGHT_SHIFT-1:0]};
      end
      if (cmd.emit) begin
         char_in = nz_ff ? b40wu_pkg::digit_to_ascii(digit_ff) : b40wu_pkg::ASCII_PAD;
         last_in = sts.last;
         dcount_in = sts.last ? count_next : '0;
         count_in = count_next;
         // advance one digit: remainder times 40
         value_in = {rem_ff, 5'b0} + {2'b0, rem_ff, 3'b0};
         left_in = left_ff - LEN_W'(1);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      rem_ff <= rem_in;
      digit_ff <= digit_in;
      nz_ff <= nz_in;
      left_ff <= left_in;
      count_ff <= count_in;
      char_ff <= char_in;
      last_ff <= last_in;
      dcount_ff <= dcount_in;
   end

   assign sts.len_zero = (len_clamp == '0);
   assign sts.last = (left_ff == LEN_W'(1));
   assign sts.out_free = ~valid_ff | rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_is_last = last_ff;
   assign rsp_decoded_count = dcount_ff;

endmodule

>>> src/b40wu_ctrl.sv
// Controller: sequences load, digit extraction and byte emission for one word.
module b40wu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output b40wu_pkg::cmd_type  cmd,
   input  b40wu_pkg::sts_type  sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               // a zero-length word gives no bytes; stay ready
               if (!sts.len_zero) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.divide = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.last ? S_IDLE : S_DIV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

>>> src/base40_word_unpack.sv
// Top level of the base-40 word unpacker: one packed word in, a run of ASCII bytes out.
//
//   channel   dir   handshake             payload
//   req       in    req_tvalid/tready     tdata: encoded_value, out_length
//   rsp       out   rsp_tvalid/tready     tdata: out_char, decoded_count; tlast: is_last
//
// A word is accepted in the idle state; each output byte then passes the divide
// state (compare bank: top digit and remainder) and the emit state (remainder
// times 40, load of the output register). The input stays busy until the last
// byte of a run is emitted; a zero-length word leaves the block ready at once.
// Reset is synchronous; the input is ready in the cycle after reset drops.
// A stall on rsp holds the byte in the output register and pauses the sequence.
module base40_word_unpack #(
   parameter int MAX_OUT_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] encoded_value, [68:64] out_length, [71:69] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [11:8] decoded_count, [15:12] zero
   output logic        rsp_tlast    // is_last
);

   b40wu_pkg::cmd_type cmd;
   b40wu_pkg::sts_type sts;

   logic [b40wu_pkg::CHAR_W-1:0]  out_char;
   logic [b40wu_pkg::COUNT_W-1:0] decoded_count;

   b40wu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   b40wu_dp #(
      .MAX_OUT_BYTES (MAX_OUT_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_encoded_value (req_tdata[63:0]),
      .req_out_length    (req_tdata[68:64]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_out_char      (out_char),
      .rsp_is_last       (rsp_tlast),
      .rsp_decoded_count (decoded_count)
   );

   assign rsp_tdata = {4'b0, decoded_count, out_char};

endmodule

>>> src/b40wu_chk.sv
// Port-level checks for the base-40 word unpacker, bound to the top level.
module b40wu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed or dropped while stalled");

   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[68:64] != 5'd0) |=> !req_tready)
      else $error("input still ready after taking a nonempty word");

   a_zero_len_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[68:64] == 5'd0) |=> req_tready)
      else $error("zero-length word made the input busy");

   a_count_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[11:8] == 4'd0)
      else $error("decoded count shown before the last byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:8] <= 4'd12) && (rsp_tdata[15:12] == 4'd0))
      else $error("decoded count out of range or pad bits set");

endmodule

bind base40_word_unpack b40wu_chk u_chk (.*);

>>> bench/base40_word_unpack_tb.sv
// Self-checking bench for the base-40 word unpacker: directed table, then random words.
module base40_word_unpack_tb;

   localparam int MAX_BYTES = 16;
   localparam int RANDOM_WORDS = 88;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [63:0] TOP_WEIGHT = 64'd419430400000000000;   // 40^11
   localparam logic [63:0] FULL_SPAN = TOP_WEIGHT * 64'd40;        // 40^12

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [3:0] count;
   } byte_exp_type;

   // listed rows carry their expectation: at most one character, then padding
   typedef struct packed {
      logic [63:0] value;
      logic [4:0]  len;
      logic        listed;
      logic [7:0]  lead;
      logic [3:0]  count;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 22;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{64'd0,                   5'd1,  1'b1, 8'h00, 4'd0},
      '{64'd0,                   5'd16, 1'b1, 8'h00, 4'd0},
      '{64'd0,                   5'd0,  1'b1, 8'h00, 4'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 5'd0,  1'b1, 8'h00, 4'd0},
      '{64'd0,                   5'd31, 1'b1, 8'h00, 4'd0},
      '{TOP_WEIGHT,              5'd1,  1'b1, "A",   4'd1},
      '{TOP_WEIGHT,              5'd3,  1'b1, "A",   4'd1},
      '{TOP_WEIGHT * 64'd26,     5'd2,  1'b1, "Z",   4'd1},
      '{TOP_WEIGHT * 64'd27,     5'd2,  1'b1, "$",   4'd1},
      '{TOP_WEIGHT * 64'd28,     5'd2,  1'b1, ".",   4'd1},
      '{TOP_WEIGHT * 64'd29,     5'd2,  1'b1, "_",   4'd1},
      '{TOP_WEIGHT * 64'd30,     5'd2,  1'b1, "0",   4'd1},
      '{TOP_WEIGHT * 64'd39,     5'd2,  1'b1, "9",   4'd1},
      '{FULL_SPAN,               5'd4,  1'b1, " ",   4'd1},
      '{TOP_WEIGHT * 64'd43,     5'd2,  1'b1, "C",   4'd1},
      '{TOP_WEIGHT,              5'd17, 1'b1, "A",   4'd1},
      '{64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0, 8'h00, 4'd0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 1'b0, 8'h00, 4'd0},
      '{64'd1,                   5'd16, 1'b0, 8'h00, 4'd0},
      '{64'd1,                   5'd12, 1'b0, 8'h00, 4'd0},
      '{64'h0123_4567_89AB_CDEF, 5'd12, 1'b0, 8'h00, 4'd0},
      '{64'h8000_0000_0000_0000, 5'd5,  1'b0, 8'h00, 4'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;    // [63:0] encoded_value, [68:64] out_length, [71:69] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] out_char, [11:8] decoded_count, [15:12] zero
   logic        rsp_tlast;         // is_last

   byte_exp_type expected_bytes [$];
   bit  steady = 1'b0;
   int  mismatches = 0;
   int  bytes_checked = 0;
   int  words_sent = 0;
   int  empty_words = 0;
   int  wide_words = 0;
   int  quiet_cycles = 0;
   int  rsp_hold = 0;

   base40_word_unpack #(
      .MAX_OUT_BYTES(MAX_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] digit_char(input logic [63:0] d);
      if (d == 0) return " ";
      if (d <= 26) return 8'("A") + 8'(d - 1);
      if (d == 27) return "$";
      if (d == 28) return ".";
      if (d == 29) return "_";
      return 8'("0") + 8'(d - 30);
   endfunction

   // expected bytes of one run: decoded characters, zero padding, count on the last
   task automatic predict_run(input logic [63:0] value, input logic [4:0] len);
      logic [63:0]  rest;
      logic [3:0]   decoded;
      int           n;
      byte_exp_type e;
      rest = value;
      decoded = 4'd0;
      n = (len > MAX_BYTES) ? MAX_BYTES : int'(len);
      for (int i = 0; i < n; i++) begin
         e.ch = 8'h00;
         if (rest != 0) begin
            e.ch = digit_char((rest / TOP_WEIGHT) % 64'd40);
            rest = (rest % TOP_WEIGHT) * 64'd40;
            decoded++;
         end
         e.last = (i == n - 1);
         e.count = e.last ? decoded : 4'd0;
         expected_bytes.push_back(e);
      end
   endtask

   task automatic queue_listed(input stim_row_type row);
      int           n;
      byte_exp_type e;
      n = (row.len > MAX_BYTES) ? MAX_BYTES : int'(row.len);
      for (int i = 0; i < n; i++) begin
         e.ch = (i == 0 && row.count != 0) ? row.lead : 8'h00;
         e.last = (i == n - 1);
         e.count = e.last ? row.count : 4'd0;
         expected_bytes.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 20)
         $display("byte %0d: %s is %0h, expected %0h", bytes_checked, what, got, want);
   endtask

   // returns just after the accepting rising edge
   task automatic send_word(input logic [63:0] value, input logic [4:0] len);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, len, value};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (len == 0) empty_words++;
      if (value >= FULL_SPAN) wide_words++;
   endtask

   function automatic logic [63:0] random_word();
      logic [63:0] v;
      int          k;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 15) return {$urandom, $urandom};
      if (r < 25) return {$urandom, $urandom} | 64'hF000_0000_0000_0000;
      // well-formed word: k leading digits, then zero digits
      k = $urandom_range(0, 12);
      v = 64'd0;
      for (int i = 0; i < 12; i++)
         v = v * 64'd40 + ((i < k) ? 64'($urandom_range(0, 39)) : 64'd0);
      return v;
   endfunction

   function automatic logic [4:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 5'd0;
      if (r < 70) return 5'($urandom_range(1, 6));
      if (r < 90) return 5'($urandom_range(7, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   // stall the result side in random bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
   end

   always @(posedge clock) begin : check_bytes
      byte_exp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unrequested byte", 64'(rsp_tdata), 64'd0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.ch)
               report_mismatch("out_char", 64'(rsp_tdata[7:0]), 64'(want.ch));
            if (rsp_tlast !== want.last)
               report_mismatch("is_last", 64'(rsp_tlast), 64'(want.last));
            if (rsp_tdata[11:8] !== want.count)
               report_mismatch("decoded_count", 64'(rsp_tdata[11:8]), 64'(want.count));
         end
         bytes_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** base40_word_unpack: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] v;
      logic [4:0]  n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].value, directed_rows[i].len);
         if (directed_rows[i].listed)
            queue_listed(directed_rows[i]);
         else
            predict_run(directed_rows[i].value, directed_rows[i].len);
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // switch idling off for whole stretches now and then
         if (i % 20 == 0) steady = (i == 40) || ($urandom_range(0, 3) == 0);
         v = random_word();
         n = random_length();
         send_word(v, n);
         predict_run(v, n);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words (%0d of zero length, %0d at or above 40^12)",
               words_sent, empty_words, wide_words);
      $display("checked %0d bytes, %0d mismatches", bytes_checked, mismatches);
      if (mismatches == 0)
         $display("** base40_word_unpack: PASSED **");
      else
         $display("** base40_word_unpack: FAILED **");
      $finish;
   end

endmodule
